/* sv/tspr_pkg.sv */
// Shared types, register indexes and coefficient tables of the three-shear pixel rotator.
`default_nettype none

package tspr_pkg;

	// Configuration register indexes
	localparam int CFG_IDX_W = 3;
	localparam logic [CFG_IDX_W-1:0] REG_ANGLE     = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SLICE_W   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SLICE_H   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_X   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_Y   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X  = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y  = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_LIGHTEN   = 3'd7;
	localparam int CFG_DATA_W = 16;

	// Offset from the slice centre and rotated position widths
	localparam int OFS_W = 10;
	localparam int POS_W = 12;

	// Angle handling constants
	localparam logic [8:0] DEG_90  = 9'd90;
	localparam logic [8:0] DEG_180 = 9'd180;
	localparam logic [8:0] DEG_270 = 9'd270;
	localparam logic [8:0] DEG_360 = 9'd360;
	// floor(2^24 / 360), used to estimate angle / 360
	localparam logic [15:0] RECIP_360 = 16'd46603;
	localparam int RECIP_SHIFT = 24;

	// Colour lightening
	localparam logic [8:0] LIGHTEN_STEP = 9'd20;
	localparam logic [7:0] COLOR_MAX = 8'd255;

	typedef struct packed {
		logic [15:0] angle_deg;
		logic [8:0]  slice_width;
		logic [8:0]  slice_height;
		logic [15:0] scale_x_q8;
		logic [15:0] scale_y_q8;
		logic [15:0] origin_x;
		logic [15:0] origin_y;
		logic        lighten_enable;
	} cfg_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} color_t;

	// tan(d/2) for d = 0..90 degrees, Q1.14
	localparam logic [14:0] HALF_TAN_TAB [91] = '{
		15'd0, 15'd143, 15'd286, 15'd429, 15'd572, 15'd715, 15'd859, 15'd1002, 15'd1146,
		15'd1289, 15'd1433, 15'd1578, 15'd1722, 15'd1867, 15'd2012, 15'd2157, 15'd2303,
		15'd2449, 15'd2595, 15'd2742, 15'd2889, 15'd3037, 15'd3185, 15'd3333, 15'd3483,
		15'd3632, 15'd3783, 15'd3933, 15'd4085, 15'd4237, 15'd4390, 15'd4544, 15'd4698,
		15'd4853, 15'd5009, 15'd5166, 15'd5323, 15'd5482, 15'd5641, 15'd5802, 15'd5963,
		15'd6126, 15'd6289, 15'd6454, 15'd6620, 15'd6786, 15'd6955, 15'd7124, 15'd7295,
		15'd7467, 15'd7640, 15'd7815, 15'd7991, 15'd8169, 15'd8348, 15'd8529, 15'd8712,
		15'd8896, 15'd9082, 15'd9270, 15'd9459, 15'd9651, 15'd9845, 15'd10040, 15'd10238,
		15'd10438, 15'd10640, 15'd10844, 15'd11051, 15'd11260, 15'd11472, 15'd11687,
		15'd11904, 15'd12124, 15'd12346, 15'd12572, 15'd12801, 15'd13032, 15'd13268,
		15'd13506, 15'd13748, 15'd13993, 15'd14242, 15'd14495, 15'd14752, 15'd15013,
		15'd15278, 15'd15548, 15'd15822, 15'd16101, 15'd16384
	};

	// sin(d) for d = 0..90 degrees, Q1.14
	localparam logic [14:0] SINE_TAB [91] = '{
		15'd0, 15'd286, 15'd572, 15'd857, 15'd1143, 15'd1428, 15'd1713, 15'd1997, 15'd2280,
		15'd2563, 15'd2845, 15'd3126, 15'd3406, 15'd3686, 15'd3964, 15'd4240, 15'd4516,
		15'd4790, 15'd5063, 15'd5334, 15'd5604, 15'd5872, 15'd6138, 15'd6402, 15'd6664,
		15'd6924, 15'd7182, 15'd7438, 15'd7692, 15'd7943, 15'd8192, 15'd8438, 15'd8682,
		15'd8923, 15'd9162, 15'd9397, 15'd9630, 15'd9860, 15'd10087, 15'd10311, 15'd10531,
		15'd10749, 15'd10963, 15'd11174, 15'd11381, 15'd11585, 15'd11786, 15'd11982,
		15'd12176, 15'd12365, 15'd12551, 15'd12733, 15'd12911, 15'd13085, 15'd13255,
		15'd13421, 15'd13583, 15'd13741, 15'd13894, 15'd14044, 15'd14189, 15'd14330,
		15'd14466, 15'd14598, 15'd14726, 15'd14849, 15'd14968, 15'd15082, 15'd15191,
		15'd15296, 15'd15396, 15'd15491, 15'd15582, 15'd15668, 15'd15749, 15'd15826,
		15'd15897, 15'd15964, 15'd16026, 15'd16083, 15'd16135, 15'd16182, 15'd16225,
		15'd16262, 15'd16294, 15'd16322, 15'd16344, 15'd16362, 15'd16374, 15'd16382,
		15'd16384
	};

endpackage

`default_nettype wire

/* sv/tspr_cfg_regs.sv */
// Configuration register file of the three-shear pixel rotator.
`default_nettype none

module tspr_cfg_regs (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_valid,
	output logic                               cfg_ready,
	input  wire logic [tspr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [tspr_pkg::CFG_DATA_W-1:0] cfg_data,
	output tspr_pkg::cfg_t                     cfg
);
	import tspr_pkg::*;

	cfg_t cfg_q;

	// Always take a write request
	assign cfg_ready = 1'b1;
	assign cfg = cfg_q;

	// Write the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.angle_deg      <= 16'd0;
			cfg_q.slice_width    <= 9'd16;
			cfg_q.slice_height   <= 9'd16;
			cfg_q.scale_x_q8     <= 16'd256;
			cfg_q.scale_y_q8     <= 16'd256;
			cfg_q.origin_x       <= 16'd0;
			cfg_q.origin_y       <= 16'd0;
			cfg_q.lighten_enable <= 1'b0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ANGLE:    cfg_q.angle_deg      <= cfg_data;
				REG_SLICE_W:  cfg_q.slice_width    <= cfg_data[8:0];
				REG_SLICE_H:  cfg_q.slice_height   <= cfg_data[8:0];
				REG_SCALE_X:  cfg_q.scale_x_q8     <= cfg_data;
				REG_SCALE_Y:  cfg_q.scale_y_q8     <= cfg_data;
				REG_ORIGIN_X: cfg_q.origin_x       <= cfg_data;
				REG_ORIGIN_Y: cfg_q.origin_y       <= cfg_data;
				REG_LIGHTEN:  cfg_q.lighten_enable <= cfg_data[0];
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

/* sv/tspr_front.sv */
// Front stages: transparency drop, lightening, angle reduction, centring, coefficient lookup.
`default_nettype none

module tspr_front #(
	parameter int MAX_SLICE_DIM  = 256,
	parameter int COEF_FRAC_BITS = 14
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire tspr_pkg::cfg_t                  cfg,
	input  wire logic                            up_valid,
	output logic                                 up_stall,
	input  wire logic [7:0]                      src_u,
	input  wire logic [7:0]                      src_v,
	input  wire tspr_pkg::color_t                up_color,
	input  wire logic [7:0]                      above_alpha,
	output logic                                 dn_valid,
	input  wire logic                            dn_stall,
	output tspr_pkg::color_t                     dn_color,
	output logic signed [tspr_pkg::OFS_W-1:0]    dx,
	output logic signed [tspr_pkg::OFS_W-1:0]    dy,
	output logic signed [COEF_FRAC_BITS+1:0]     tn,
	output logic signed [COEF_FRAC_BITS+1:0]     sn
);
	import tspr_pkg::*;

	localparam int CW  = COEF_FRAC_BITS + 2;
	localparam int LSH = (COEF_FRAC_BITS >= 14) ? COEF_FRAC_BITS - 14 : 0;
	localparam int RSH = (COEF_FRAC_BITS < 14) ? 14 - COEF_FRAC_BITS : 0;
	localparam int RND = (1 << RSH) >> 1;

	// Bring a Q1.14 entry to the configured fraction width, rounding half up
	function automatic logic [CW-2:0] coef_scale(input logic [14:0] v);
		logic [31:0] x;
		x = 32'(v);
		if (COEF_FRAC_BITS >= 14) begin
			x = x << LSH;
		end else begin
			x = (x + 32'(RND)) >> RSH;
		end
		return x[CW-2:0];
	endfunction

	function automatic logic [7:0] brighten(input logic [7:0] c);
		logic [8:0] s;
		s = {1'b0, c} + LIGHTEN_STEP;
		return s[8] ? COLOR_MAX : s[7:0];
	endfunction

	logic move_s1, move_s2, move_s3;
	logic v_s1, v_s2, v_s3;

	// Stage 1 registers
	color_t                  col_s1;
	logic [15:0]             ang_s1;
	logic [31:0]             quo_s1;
	logic signed [OFS_W-1:0] dxn_s1, dxf_s1, dyn_s1, dyf_s1;
	// Stage 2 registers
	color_t                  col_s2;
	logic [8:0]              r_s2;
	logic signed [OFS_W-1:0] dxn_s2, dxf_s2, dyn_s2, dyf_s2;
	// Stage 3 registers
	color_t                  col_s3;
	logic signed [OFS_W-1:0] dx_s3, dy_s3;
	logic signed [CW-1:0]    tn_s3, sn_s3;

	// Stage 1 logic
	logic               lit;
	color_t             col_in;
	logic signed [16:0] ang_x;
	logic [16:0]        ang_abs;
	logic [8:0]         w_c, h_c;
	logic [7:0]         cx, cy;

	// Stage 2 logic
	logic [7:0]  quo;
	logic [16:0] qm, rem;

	// Stage 3 logic
	logic                flip;
	logic signed [9:0]   t;
	logic [6:0]          idx;
	logic [CW-2:0]       tn_mag, sn_mag;

	// Advance a stage when it is empty or the next one advances
	assign move_s3  = !v_s3 || !dn_stall;
	assign move_s2  = !v_s2 || move_s3;
	assign move_s1  = !v_s1 || move_s2;
	assign up_stall = !move_s1;

	// Lighten, start the angle / 360 estimate, form both centred offsets
	always_comb begin
		lit = cfg.lighten_enable && (above_alpha == 8'd0);
		col_in = up_color;
		if (lit) begin
			col_in.red   = brighten(up_color.red);
			col_in.green = brighten(up_color.green);
			col_in.blue  = brighten(up_color.blue);
		end
		ang_x   = {cfg.angle_deg[15], cfg.angle_deg};
		ang_abs = ang_x[16] ? 17'(-ang_x) : 17'(ang_x);
		w_c = (32'(cfg.slice_width) > MAX_SLICE_DIM) ? 9'(MAX_SLICE_DIM) : cfg.slice_width;
		h_c = (32'(cfg.slice_height) > MAX_SLICE_DIM) ? 9'(MAX_SLICE_DIM) : cfg.slice_height;
		cx = w_c[8:1];
		cy = h_c[8:1];
	end

	// Finish the remainder by 360 with one correction step
	always_comb begin
		quo = quo_s1[RECIP_SHIFT+7:RECIP_SHIFT];
		qm  = 17'(quo) * 17'(DEG_360);
		rem = 17'(ang_s1) - qm;
		if (rem >= 17'(DEG_360)) begin
			rem = rem - 17'(DEG_360);
		end
	end

	// Pick flip and shear angle, look up coefficients
	always_comb begin
		flip = (r_s2 < DEG_90) || (r_s2 > DEG_270);
		if (flip) begin
			t = (r_s2 > DEG_270) ? $signed({1'b0, r_s2}) - $signed({1'b0, DEG_360})
			                     : $signed({1'b0, r_s2});
		end else begin
			t = $signed({1'b0, r_s2}) - $signed({1'b0, DEG_180});
		end
		idx    = t[9] ? 7'(-t) : 7'(t);
		tn_mag = coef_scale(HALF_TAN_TAB[idx]);
		sn_mag = coef_scale(SINE_TAB[idx]);
	end

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (move_s1) begin
				v_s1 <= up_valid && (up_color.alpha != 8'd0);
			end
			if (move_s2) begin
				v_s2 <= v_s1;
			end
			if (move_s3) begin
				v_s3 <= v_s2;
			end
		end
	end

	// Payload
	always_ff @(posedge clk) begin
		if (move_s1) begin
			col_s1 <= col_in;
			ang_s1 <= ang_abs[15:0];
			quo_s1 <= 32'(ang_abs) * 32'(RECIP_360);
			dxn_s1 <= $signed({2'b00, src_u}) - $signed({2'b00, cx});
			dxf_s1 <= $signed({1'b0, w_c}) - $signed({2'b00, src_u}) - $signed({2'b00, cx});
			dyn_s1 <= $signed({2'b00, src_v}) - $signed({2'b00, cy});
			dyf_s1 <= $signed({1'b0, h_c}) - $signed({2'b00, src_v}) - $signed({2'b00, cy});
		end
		if (move_s2) begin
			col_s2 <= col_s1;
			r_s2   <= rem[8:0];
			dxn_s2 <= dxn_s1;
			dxf_s2 <= dxf_s1;
			dyn_s2 <= dyn_s1;
			dyf_s2 <= dyf_s1;
		end
		if (move_s3) begin
			col_s3 <= col_s2;
			dx_s3  <= flip ? dxf_s2 : dxn_s2;
			dy_s3  <= flip ? dyf_s2 : dyn_s2;
			tn_s3  <= t[9] ? -$signed({1'b0, tn_mag}) : $signed({1'b0, tn_mag});
			sn_s3  <= t[9] ? -$signed({1'b0, sn_mag}) : $signed({1'b0, sn_mag});
		end
	end

	assign dn_valid = v_s3;
	assign dn_color = col_s3;
	assign dx = dx_s3;
	assign dy = dy_s3;
	assign tn = tn_s3;
	assign sn = sn_s3;

	a_opaque_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(up_valid && !up_stall && (up_color.alpha != 8'd0)) |=> v_s1)
		else $error("opaque pixel request not loaded into stage 1");

	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2 |-> (r_s2 < DEG_360))
		else $error("reduced angle out of range");

	a_hold_s3: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && dn_stall) |=> (v_s3 && $stable(dx_s3) && $stable(tn_s3)))
		else $error("stage 3 changed while stalled");

endmodule

`default_nettype wire

/* sv/tspr_shear.sv */
// Three shear stages: x, then y, then x, each rounded half away from zero.
`default_nettype none

module tspr_shear #(
	parameter int COEF_FRAC_BITS = 14
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            up_valid,
	output logic                                 up_stall,
	input  wire tspr_pkg::color_t                up_color,
	input  wire logic signed [tspr_pkg::OFS_W-1:0] dx,
	input  wire logic signed [tspr_pkg::OFS_W-1:0] dy,
	input  wire logic signed [COEF_FRAC_BITS+1:0]  tn,
	input  wire logic signed [COEF_FRAC_BITS+1:0]  sn,
	output logic                                 dn_valid,
	input  wire logic                            dn_stall,
	output tspr_pkg::color_t                     dn_color,
	output logic signed [tspr_pkg::POS_W-1:0]    pos_x,
	output logic signed [tspr_pkg::POS_W-1:0]    pos_y
);
	import tspr_pkg::*;

	localparam int CW = COEF_FRAC_BITS + 2;
	localparam int SW = POS_W + CW + 1;

	// Divide by 2^COEF_FRAC_BITS, rounding half away from zero
	function automatic logic signed [POS_W-1:0] rnd(input logic signed [SW-1:0] p);
		logic [SW-1:0] m;
		logic [SW-1:0] q;
		m = p[SW-1] ? SW'(-p) : SW'(p);
		q = (m + (SW'(1) << (COEF_FRAC_BITS - 1))) >> COEF_FRAC_BITS;
		return p[SW-1] ? -$signed(q[POS_W-1:0]) : $signed(q[POS_W-1:0]);
	endfunction

	logic move_s4, move_s5, move_s6;
	logic v_s4, v_s5, v_s6;

	color_t                  col_s4, col_s5, col_s6;
	logic signed [POS_W-1:0] x1_s4, x1_s5, y1_s5, y1_s6, x2_s6;
	logic signed [OFS_W-1:0] dy_s4;
	logic signed [CW-1:0]    tn_s4, sn_s4, tn_s5;

	logic signed [OFS_W+CW-1:0] p_dy_tn;
	logic signed [POS_W+CW-1:0] p_x1_sn, p_y1_tn;
	logic signed [SW-1:0]       sum1, sum2, sum3;

	assign move_s6  = !v_s6 || !dn_stall;
	assign move_s5  = !v_s5 || move_s6;
	assign move_s4  = !v_s4 || move_s5;
	assign up_stall = !move_s4;

	// One product and one rounded sum per stage
	always_comb begin
		p_dy_tn = dy * tn;
		sum1    = (SW'(dx) <<< COEF_FRAC_BITS) - SW'(p_dy_tn);
		p_x1_sn = x1_s4 * sn_s4;
		sum2    = SW'(p_x1_sn) + (SW'(dy_s4) <<< COEF_FRAC_BITS);
		p_y1_tn = y1_s5 * tn_s5;
		sum3    = (SW'(x1_s5) <<< COEF_FRAC_BITS) - SW'(p_y1_tn);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (move_s4) begin
				v_s4 <= up_valid;
			end
			if (move_s5) begin
				v_s5 <= v_s4;
			end
			if (move_s6) begin
				v_s6 <= v_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move_s4) begin
			col_s4 <= up_color;
			x1_s4  <= rnd(sum1);
			dy_s4  <= dy;
			tn_s4  <= tn;
			sn_s4  <= sn;
		end
		if (move_s5) begin
			col_s5 <= col_s4;
			x1_s5  <= x1_s4;
			y1_s5  <= rnd(sum2);
			tn_s5  <= tn_s4;
		end
		if (move_s6) begin
			col_s6 <= col_s5;
			y1_s6  <= y1_s5;
			x2_s6  <= rnd(sum3);
		end
	end

	assign dn_valid = v_s6;
	assign dn_color = col_s6;
	assign pos_x = x2_s6;
	assign pos_y = y1_s6;

endmodule

`default_nettype wire

/* sv/tspr_place.sv */
// Output stages: Q8.8 scaling, origin offset with saturation, fill size, output register.
`default_nettype none

module tspr_place (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire tspr_pkg::cfg_t                 cfg,
	input  wire logic                           up_valid,
	output logic                                up_stall,
	input  wire tspr_pkg::color_t               up_color,
	input  wire logic signed [tspr_pkg::POS_W-1:0] pos_x,
	input  wire logic signed [tspr_pkg::POS_W-1:0] pos_y,
	output logic                                dn_valid,
	input  wire logic                           dn_stall,
	output tspr_pkg::color_t                    dn_color,
	output logic signed [15:0]                  dest_x,
	output logic signed [15:0]                  dest_y,
	output logic [8:0]                          fill_width,
	output logic [8:0]                          fill_height
);
	import tspr_pkg::*;

	localparam int PW = POS_W + 17;

	// Truncate a scaled position toward zero, add the origin, saturate
	function automatic logic signed [15:0] settle(input logic signed [PW-1:0] p,
	                                              input logic [15:0] origin);
		logic [PW-1:0]      m;
		logic [PW-9:0]      tq;
		logic signed [23:0] s;
		m  = p[PW-1] ? PW'(-p) : PW'(p);
		tq = m[PW-1:8];
		s  = p[PW-1] ? -$signed(24'(tq)) : $signed(24'(tq));
		s  = s + 24'($signed(origin));
		if (s > 24'sd32767) begin
			return 16'sh7FFF;
		end else if (s < -24'sd32768) begin
			return 16'sh8000;
		end
		return s[15:0];
	endfunction

	logic move_s7, move_s8;
	logic v_s7, v_s8;

	color_t               col_s7, col_s8;
	logic signed [PW-1:0] px_s7, py_s7;
	logic signed [15:0]   dx_s8, dy_s8;
	logic [8:0]           fw_s8, fh_s8;
	logic [16:0]          fw_sum, fh_sum;

	assign move_s8  = !v_s8 || !dn_stall;
	assign move_s7  = !v_s7 || move_s8;
	assign up_stall = !move_s7;

	// Round the scale factors up to whole pixels
	assign fw_sum = {1'b0, cfg.scale_x_q8} + 17'd255;
	assign fh_sum = {1'b0, cfg.scale_y_q8} + 17'd255;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
		end else begin
			if (move_s7) begin
				v_s7 <= up_valid;
			end
			if (move_s8) begin
				v_s8 <= v_s7;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (move_s7) begin
			col_s7 <= up_color;
			px_s7  <= pos_x * $signed({1'b0, cfg.scale_x_q8});
			py_s7  <= pos_y * $signed({1'b0, cfg.scale_y_q8});
		end
		if (move_s8) begin
			col_s8 <= col_s7;
			dx_s8  <= settle(px_s7, cfg.origin_x);
			dy_s8  <= settle(py_s7, cfg.origin_y);
			fw_s8  <= fw_sum[16:8];
			fh_s8  <= fh_sum[16:8];
		end
	end

	assign dn_valid    = v_s8;
	assign dn_color    = col_s8;
	assign dest_x      = dx_s8;
	assign dest_y      = dy_s8;
	assign fill_width  = fw_s8;
	assign fill_height = fh_s8;

	a_load_s8: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s7 && move_s8) |=> v_s8)
		else $error("stage 7 request lost on its way to the output");

	a_hold_out: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s8 && dn_stall) |=> (v_s8 && $stable(dx_s8) && $stable(col_s8)))
		else $error("output register changed while stalled");

endmodule

`default_nettype wire

/* sv/three_shear_pixel_rotator.sv */
// Top level of the three-shear pixel rotator.
//
// Maps one sprite pixel per cycle to a filled screen rectangle. The datapath is an
// eight-stage pipeline: three front stages (lightening, angle remainder by 360,
// centring and coefficient lookup), three shear stages (one multiply and rounded
// sum each) and two placement stages (Q8.8 scale multiply, then origin add with
// saturation into the output register). A pixel is accepted in every cycle that
// in_stall is low; the stage-to-stage stall chain lets new pixels fill empty
// stages while a result waits. Pixels with alpha zero are dropped at the first
// stage and give no result. cfg_ready is always high; write registers only while
// no pixel is in flight.
`default_nettype none

module three_shear_pixel_rotator #(
	parameter int MAX_SLICE_DIM  = 256,
	parameter int COEF_FRAC_BITS = 14
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_valid,
	output logic                                  cfg_ready,
	input  wire logic [tspr_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [tspr_pkg::CFG_DATA_W-1:0]  cfg_data,
	input  wire logic                             in_valid,
	output logic                                  in_stall,
	input  wire logic [7:0]                       src_u,
	input  wire logic [7:0]                       src_v,
	input  wire logic [7:0]                       in_red,
	input  wire logic [7:0]                       in_green,
	input  wire logic [7:0]                       in_blue,
	input  wire logic [7:0]                       in_alpha,
	input  wire logic [7:0]                       above_alpha,
	output logic                                  out_valid,
	input  wire logic                             out_stall,
	output logic signed [15:0]                    dest_x,
	output logic signed [15:0]                    dest_y,
	output logic [8:0]                            fill_width,
	output logic [8:0]                            fill_height,
	output logic [7:0]                            out_red,
	output logic [7:0]                            out_green,
	output logic [7:0]                            out_blue,
	output logic [7:0]                            out_alpha
);
	import tspr_pkg::*;

	localparam int CW = COEF_FRAC_BITS + 2;

	cfg_t   cfg;
	color_t in_color, fr_color, sh_color, pl_color;

	logic                    fr_valid, fr_stall, sh_valid, sh_stall;
	logic signed [OFS_W-1:0] fr_dx, fr_dy;
	logic signed [CW-1:0]    fr_tn, fr_sn;
	logic signed [POS_W-1:0] sh_x, sh_y;

	assign in_color = '{red: in_red, green: in_green, blue: in_blue, alpha: in_alpha};

	tspr_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	tspr_front #(
		.MAX_SLICE_DIM  (MAX_SLICE_DIM),
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.up_valid    (in_valid),
		.up_stall    (in_stall),
		.src_u       (src_u),
		.src_v       (src_v),
		.up_color    (in_color),
		.above_alpha (above_alpha),
		.dn_valid    (fr_valid),
		.dn_stall    (fr_stall),
		.dn_color    (fr_color),
		.dx          (fr_dx),
		.dy          (fr_dy),
		.tn          (fr_tn),
		.sn          (fr_sn)
	);

	tspr_shear #(
		.COEF_FRAC_BITS (COEF_FRAC_BITS)
	) u_shear (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (fr_valid),
		.up_stall (fr_stall),
		.up_color (fr_color),
		.dx       (fr_dx),
		.dy       (fr_dy),
		.tn       (fr_tn),
		.sn       (fr_sn),
		.dn_valid (sh_valid),
		.dn_stall (sh_stall),
		.dn_color (sh_color),
		.pos_x    (sh_x),
		.pos_y    (sh_y)
	);

	tspr_place u_place (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.up_valid    (sh_valid),
		.up_stall    (sh_stall),
		.up_color    (sh_color),
		.pos_x       (sh_x),
		.pos_y       (sh_y),
		.dn_valid    (out_valid),
		.dn_stall    (out_stall),
		.dn_color    (pl_color),
		.dest_x      (dest_x),
		.dest_y      (dest_y),
		.fill_width  (fill_width),
		.fill_height (fill_height)
	);

	assign out_red   = pl_color.red;
	assign out_green = pl_color.green;
	assign out_blue  = pl_color.blue;
	assign out_alpha = pl_color.alpha;

endmodule

`default_nettype wire

/* bench/three_shear_pixel_rotator_tb.sv */
// Self-checking testbench for the three-shear pixel rotator: directed table, then random phases.
`timescale 1ns / 1ps

module three_shear_pixel_rotator_tb;
	import tspr_pkg::*;

	localparam int MAX_DIM = 256;
	localparam int FRAC = 14;
	localparam int DRAIN_CYCLES = 16;
	localparam int NUM_PHASES = 48;
	localparam int ITEMS_PER_PHASE = 30;
	localparam int CALM_PHASES = 6;
	localparam int HOLD_PHASE = 5;
	localparam int TURN_POINTS [11] = '{0, 89, 90, 91, 179, 180, 181, 269, 270, 271, 359};

	typedef struct packed {
		logic [7:0] u;
		logic [7:0] v;
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
		logic [7:0] above;
	} pixel_t;

	typedef struct packed {
		logic signed [15:0] dest_x;
		logic signed [15:0] dest_y;
		logic [8:0]         fill_w;
		logic [8:0]         fill_h;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic [7:0]         alpha;
	} rect_t;

	typedef struct {
		bit                   wr;
		logic [CFG_IDX_W-1:0] idx;
		logic [15:0]          data;
		pixel_t               pix;
		bit                   typed;
		rect_t                res;
	} step_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic [7:0]            src_u = '0;
	logic [7:0]            src_v = '0;
	logic [7:0]            in_red = '0;
	logic [7:0]            in_green = '0;
	logic [7:0]            in_blue = '0;
	logic [7:0]            in_alpha = '0;
	logic [7:0]            above_alpha = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic signed [15:0]    dest_x;
	logic signed [15:0]    dest_y;
	logic [8:0]            fill_width;
	logic [8:0]            fill_height;
	logic [7:0]            out_red;
	logic [7:0]            out_green;
	logic [7:0]            out_blue;
	logic [7:0]            out_alpha;

	cfg_t      shadow_cfg;
	rect_t     pending_rects [$];
	step_row_t steps [$];
	int        mismatches = 0;
	int        rects_checked = 0;
	int        pixels_sent = 0;
	int        transparent_sent = 0;
	int        settings_used = 0;
	int        tx_gap_pct = 0;
	int        rx_stall_pct = 0;
	int        rx_stall_left = 0;

	three_shear_pixel_rotator #(
		.MAX_SLICE_DIM (MAX_DIM),
		.COEF_FRAC_BITS(FRAC)
	) u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.src_u      (src_u),
		.src_v      (src_v),
		.in_red     (in_red),
		.in_green   (in_green),
		.in_blue    (in_blue),
		.in_alpha   (in_alpha),
		.above_alpha(above_alpha),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.dest_x     (dest_x),
		.dest_y     (dest_y),
		.fill_width (fill_width),
		.fill_height(fill_height),
		.out_red    (out_red),
		.out_green  (out_green),
		.out_blue   (out_blue),
		.out_alpha  (out_alpha)
	);

	always #6 clk = ~clk;

	// Divide by 2^FRAC, rounding half away from zero
	function automatic longint shear_round(longint p);
		longint m;
		m = (p < 0) ? -p : p;
		m = (m + (longint'(1) << (FRAC - 1))) >> FRAC;
		return (p < 0) ? -m : m;
	endfunction

	// Scale by Q8.8, truncate toward zero, add origin, saturate
	function automatic logic [15:0] screen_coord(longint pos, logic [15:0] scale,
			logic signed [15:0] org);
		longint s;
		s = (pos * longint'(scale)) / 256 + longint'(org);
		if (s > 32767)
			s = 32767;
		if (s < -32768)
			s = -32768;
		return s[15:0];
	endfunction

	function automatic logic [7:0] lighten(logic [7:0] c);
		int s;
		s = int'(c) + int'(LIGHTEN_STEP);
		return (s > 255) ? COLOR_MAX : s[7:0];
	endfunction

	// Expected rectangle for one pixel; returns 0 when the pixel is dropped
	function automatic bit rotate_pixel(cfg_t c, pixel_t pix, output rect_t res);
		int     ang, t, idx;
		bit     flip;
		longint tn, sn, w, h, dx, dy, one, x1, y1, x2;
		res = '0;
		if (pix.alpha == 0)
			return 0;
		res.red = pix.red;
		res.green = pix.green;
		res.blue = pix.blue;
		res.alpha = pix.alpha;
		if (c.lighten_enable && pix.above == 0) begin
			res.red = lighten(pix.red);
			res.green = lighten(pix.green);
			res.blue = lighten(pix.blue);
		end
		// reduce the angle and pick the shear angle
		ang = int'($signed(c.angle_deg)) % 360;
		if (ang < 0)
			ang = -ang;
		flip = (ang < 90) || (ang > 270);
		if (flip)
			t = (ang > 270) ? ang - 360 : ang;
		else
			t = ang - 180;
		idx = (t < 0) ? -t : t;
		if (idx > 90)
			idx = 90;
		tn = longint'(HALF_TAN_TAB[idx]);
		sn = longint'(SINE_TAB[idx]);
		if (t < 0) begin
			tn = -tn;
			sn = -sn;
		end
		// centre on the slice, flipping when asked
		w = (c.slice_width > MAX_DIM) ? MAX_DIM : longint'(c.slice_width);
		h = (c.slice_height > MAX_DIM) ? MAX_DIM : longint'(c.slice_height);
		dx = flip ? w - longint'(pix.u) - w / 2 : longint'(pix.u) - w / 2;
		dy = flip ? h - longint'(pix.v) - h / 2 : longint'(pix.v) - h / 2;
		// three shears: x, y, x
		one = longint'(1) << FRAC;
		x1 = shear_round(dx * one - dy * tn);
		y1 = shear_round(x1 * sn + dy * one);
		x2 = shear_round(x1 * one - y1 * tn);
		res.dest_x = screen_coord(x2, c.scale_x_q8, c.origin_x);
		res.dest_y = screen_coord(y1, c.scale_y_q8, c.origin_y);
		res.fill_w = 9'((int'(c.scale_x_q8) + 255) >> 8);
		res.fill_h = 9'((int'(c.scale_y_q8) + 255) >> 8);
		return 1;
	endfunction

	function automatic logic [15:0] pick_angle();
		int a;
		case ($urandom_range(0, 2))
			0: a = $urandom_range(0, 65535);
			1: a = int'($urandom_range(0, 800)) - 400;
			default: begin
				a = TURN_POINTS[$urandom_range(0, 10)];
				if ($urandom_range(0, 1))
					a = -a;
				a = a + 360 * (int'($urandom_range(0, 6)) - 3);
			end
		endcase
		return a[15:0];
	endfunction

	function automatic logic [8:0] pick_dim();
		int k;
		k = $urandom_range(0, 19);
		if (k == 0)
			return $urandom_range(0, 1) ? 9'd0 : 9'($urandom_range(257, 511));
		if (k < 3)
			return 9'd256;
		if (k < 12)
			return 9'($urandom_range(1, 32));
		return 9'($urandom_range(1, 256));
	endfunction

	function automatic logic [15:0] pick_scale();
		int k;
		k = $urandom_range(0, 9);
		if (k == 0)
			return $urandom_range(0, 1) ? 16'd0 : 16'hFFFF;
		if (k < 3)
			return 16'($urandom_range(0, 65535));
		if (k < 6)
			return 16'd256;
		return 16'($urandom_range(0, 1024));
	endfunction

	function automatic logic [15:0] pick_origin();
		int a;
		if ($urandom_range(0, 1))
			a = $urandom_range(0, 65535);
		else
			a = int'($urandom_range(0, 400)) - 200;
		return a[15:0];
	endfunction

	// Mostly inside the slice, sometimes anywhere
	function automatic logic [7:0] pick_pos(logic [8:0] dim);
		int top;
		top = (dim > MAX_DIM) ? MAX_DIM : int'(dim);
		if (top == 0 || $urandom_range(0, 4) == 0)
			return 8'($urandom_range(0, 255));
		return 8'($urandom_range(0, top - 1));
	endfunction

	function automatic pixel_t pick_pixel(cfg_t c);
		pixel_t p;
		int     k;
		p.u = pick_pos(c.slice_width);
		p.v = pick_pos(c.slice_height);
		p.red = 8'($urandom_range(0, 255));
		p.green = 8'($urandom_range(0, 255));
		p.blue = 8'($urandom_range(0, 255));
		k = $urandom_range(0, 9);
		p.alpha = (k == 0) ? 8'd0 : (k == 1) ? 8'd255 : 8'($urandom_range(1, 255));
		p.above = ($urandom_range(0, 9) < 3) ? 8'd0 : 8'($urandom_range(0, 255));
		return p;
	endfunction

	task automatic add_row(bit wr, logic [CFG_IDX_W-1:0] idx, logic [15:0] data,
			pixel_t pix, bit typed, rect_t res);
		step_row_t r;
		r.wr = wr;
		r.idx = idx;
		r.data = data;
		r.pix = pix;
		r.typed = typed;
		r.res = res;
		steps.push_back(r);
	endtask

	// Write one register; called at a falling edge, returns at one
	task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [15:0] data);
		in_valid = 1'b0;
		cfg_valid = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_ANGLE:    shadow_cfg.angle_deg = data;
			REG_SLICE_W:  shadow_cfg.slice_width = data[8:0];
			REG_SLICE_H:  shadow_cfg.slice_height = data[8:0];
			REG_SCALE_X:  shadow_cfg.scale_x_q8 = data;
			REG_SCALE_Y:  shadow_cfg.scale_y_q8 = data;
			REG_ORIGIN_X: shadow_cfg.origin_x = data;
			REG_ORIGIN_Y: shadow_cfg.origin_y = data;
			REG_LIGHTEN:  shadow_cfg.lighten_enable = data[0];
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Hold the input until every expected rectangle is out, then let the pipe empty
	task automatic wait_drained();
		in_valid = 1'b0;
		cfg_valid = 1'b0;
		while (pending_rects.size() != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES)
			@(negedge clk);
	endtask

	// Offer one pixel request and record its expected rectangle on acceptance
	task automatic send_pixel(pixel_t pix, bit typed, rect_t typed_res);
		rect_t pred;
		cfg_valid = 1'b0;
		if (tx_gap_pct != 0 && $urandom_range(0, 99) < tx_gap_pct) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 7))
				@(negedge clk);
		end
		src_u = pix.u;
		src_v = pix.v;
		in_red = pix.red;
		in_green = pix.green;
		in_blue = pix.blue;
		in_alpha = pix.alpha;
		above_alpha = pix.above;
		in_valid = 1'b1;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		pixels_sent++;
		if (pix.alpha == 0)
			transparent_sent++;
		if (typed)
			pending_rects.push_back(typed_res);
		else if (rotate_pixel(shadow_cfg, pix, pred))
			pending_rects.push_back(pred);
		@(negedge clk);
	endtask

	// Receiver: stall in bursts of random length
	always @(negedge clk) begin
		if (rx_stall_left != 0) begin
			out_stall = 1'b1;
			rx_stall_left--;
		end else if (rx_stall_pct != 0 && $urandom_range(0, 99) < rx_stall_pct) begin
			out_stall = 1'b1;
			rx_stall_left = $urandom_range(0, 6);
		end else begin
			out_stall = 1'b0;
		end
	end

	// Compare each accepted rectangle with the oldest expectation
	always @(posedge clk) begin : rect_check
		rect_t got;
		rect_t want;
		if (arst_n && out_valid && !out_stall) begin
			got.dest_x = dest_x;
			got.dest_y = dest_y;
			got.fill_w = fill_width;
			got.fill_h = fill_height;
			got.red = out_red;
			got.green = out_green;
			got.blue = out_blue;
			got.alpha = out_alpha;
			rects_checked++;
			if (pending_rects.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: unexpected rectangle x=%0d y=%0d", $realtime, dest_x, dest_y);
				mismatches++;
			end else begin
				want = pending_rects.pop_front();
				if (got !== want) begin
					if (mismatches < 10)
						$display("%0t: mismatch exp x=%0d y=%0d w=%0d h=%0d rgba=%h got x=%0d y=%0d w=%0d h=%0d rgba=%h",
							$realtime, want.dest_x, want.dest_y, want.fill_w, want.fill_h,
							{want.red, want.green, want.blue, want.alpha},
							got.dest_x, got.dest_y, got.fill_w, got.fill_h,
							{got.red, got.green, got.blue, got.alpha});
					mismatches++;
				end
			end
		end
	end

	// Watchdog
	initial begin
		#4000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin : stimulus
		cfg_t   c;
		pixel_t pix;
		int     count;
		bit     held;
		shadow_cfg.angle_deg = 16'd0;
		shadow_cfg.slice_width = 9'd16;
		shadow_cfg.slice_height = 9'd16;
		shadow_cfg.scale_x_q8 = 16'd256;
		shadow_cfg.scale_y_q8 = 16'd256;
		shadow_cfg.origin_x = 16'd0;
		shadow_cfg.origin_y = 16'd0;
		shadow_cfg.lighten_enable = 1'b0;

		// At reset: angle 0 flips, so the rectangle sits at (8 - u, 8 - v)
		add_row(0, REG_ANGLE, 16'd0, '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0}, 1,
			'{16'sd8, 16'sd8, 9'd1, 9'd1, 8'd0, 8'd0, 8'd0, 8'd1});
		add_row(0, REG_ANGLE, 16'd0, '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255}, 1,
			'{-16'sd247, -16'sd247, 9'd1, 9'd1, 8'd255, 8'd255, 8'd255, 8'd255});
		add_row(0, REG_ANGLE, 16'd0, '{8'd8, 8'd8, 8'd18, 8'd52, 8'd86, 8'd128, 8'd0}, 1,
			'{16'sd0, 16'sd0, 9'd1, 9'd1, 8'd18, 8'd52, 8'd86, 8'd128});
		add_row(0, REG_ANGLE, 16'd0, '{8'd15, 8'd0, 8'd1, 8'd2, 8'd3, 8'd200, 8'd9}, 1,
			'{-16'sd7, 16'sd8, 9'd1, 9'd1, 8'd1, 8'd2, 8'd3, 8'd200});
		add_row(0, REG_ANGLE, 16'd0, '{8'd0, 8'd15, 8'd250, 8'd9, 8'd170, 8'd99, 8'd0}, 1,
			'{16'sd8, -16'sd7, 9'd1, 9'd1, 8'd250, 8'd9, 8'd170, 8'd99});
		// transparent pixel: dropped
		add_row(0, REG_ANGLE, 16'd0, '{8'd77, 8'd66, 8'd12, 8'd34, 8'd56, 8'd0, 8'd0}, 0, '0);
		add_row(0, REG_ANGLE, 16'd0, '{8'd16, 8'd16, 8'd1, 8'd1, 8'd1, 8'd255, 8'd255}, 1,
			'{-16'sd8, -16'sd8, 9'd1, 9'd1, 8'd1, 8'd1, 8'd1, 8'd255});
		// lighten: raise by 20 with saturation only when nothing is above
		add_row(1, REG_LIGHTEN, 16'd1, '{8'd3, 8'd4, 8'd0, 8'd235, 8'd255, 8'd9, 8'd0}, 1,
			'{16'sd5, 16'sd4, 9'd1, 9'd1, 8'd20, 8'd255, 8'd255, 8'd9});
		add_row(0, REG_ANGLE, 16'd0, '{8'd3, 8'd4, 8'd0, 8'd235, 8'd255, 8'd9, 8'd1}, 1,
			'{16'sd5, 16'sd4, 9'd1, 9'd1, 8'd0, 8'd235, 8'd255, 8'd9});
		// flip boundaries and angle extremes
		add_row(1, REG_ANGLE, 16'd90, '{8'd0, 8'd0, 8'd200, 8'd100, 8'd50, 8'd77, 8'd0}, 0, '0);
		add_row(1, REG_ANGLE, 16'd270, '{8'd5, 8'd11, 8'd10, 8'd20, 8'd30, 8'd40, 8'd0}, 0, '0);
		add_row(1, REG_ANGLE, 16'h8000, '{8'd15, 8'd3, 8'd90, 8'd91, 8'd92, 8'd93, 8'd5}, 0, '0);
		add_row(1, REG_ANGLE, 16'h7FFF, '{8'd9, 8'd1, 8'd240, 8'd1, 8'd128, 8'd2, 8'd0}, 0, '0);
		add_row(1, REG_ANGLE, 16'd180, '{8'd12, 8'd2, 8'd33, 8'd44, 8'd55, 8'd66, 8'd0}, 0, '0);
		add_row(1, REG_ANGLE, 16'hFFA5, '{8'd0, 8'd255, 8'd7, 8'd8, 8'd9, 8'd10, 8'd3}, 0, '0);
		// zero and oversized slice
		add_row(1, REG_SLICE_W, 16'd0, '{8'd255, 8'd0, 8'd1, 8'd2, 8'd4, 8'd8, 8'd0}, 0, '0);
		add_row(1, REG_SLICE_H, 16'd511, '{8'd200, 8'd200, 8'd16, 8'd32, 8'd64, 8'd128, 8'd0}, 0, '0);
		// zero and full scale, origin extremes
		add_row(1, REG_SCALE_X, 16'd0, '{8'd100, 8'd50, 8'd170, 8'd85, 8'd15, 8'd240, 8'd0}, 0, '0);
		add_row(1, REG_SCALE_Y, 16'hFFFF, '{8'd1, 8'd254, 8'd85, 8'd170, 8'd240, 8'd15, 8'd0}, 0, '0);
		add_row(1, REG_ORIGIN_X, 16'h7FFF, '{8'd40, 8'd0, 8'd0, 8'd255, 8'd0, 8'd1, 8'd255}, 0, '0);
		add_row(1, REG_ORIGIN_Y, 16'h8000, '{8'd0, 8'd40, 8'd255, 8'd0, 8'd255, 8'd254, 8'd0}, 0, '0);
		add_row(0, REG_ANGLE, 16'd0, '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0}, 0, '0);
		add_row(0, REG_ANGLE, 16'd0, '{8'd0, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255}, 0, '0);

		// Reset
		repeat (3)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed table
		tx_gap_pct = 20;
		rx_stall_pct = 20;
		foreach (steps[i]) begin
			if (steps[i].wr) begin
				wait_drained();
				cfg_write(steps[i].idx, steps[i].data);
			end
			send_pixel(steps[i].pix, steps[i].typed, steps[i].res);
		end

		// Random phases, each under its own register setting
		held = 0;
		for (int p = 0; p < NUM_PHASES; p++) begin
			wait_drained();
			if (p == 0) begin
				c.angle_deg = 16'h8000;
				c.slice_width = 9'd1;
				c.slice_height = 9'd1;
				c.scale_x_q8 = 16'd0;
				c.scale_y_q8 = 16'd0;
				c.origin_x = 16'h8000;
				c.origin_y = 16'h8000;
				c.lighten_enable = 1'b0;
			end else if (p == 1) begin
				c.angle_deg = 16'h7FFF;
				c.slice_width = 9'd256;
				c.slice_height = 9'd256;
				c.scale_x_q8 = 16'hFFFF;
				c.scale_y_q8 = 16'hFFFF;
				c.origin_x = 16'h7FFF;
				c.origin_y = 16'h7FFF;
				c.lighten_enable = 1'b1;
			end else begin
				c.angle_deg = pick_angle();
				c.slice_width = pick_dim();
				c.slice_height = pick_dim();
				c.scale_x_q8 = pick_scale();
				c.scale_y_q8 = pick_scale();
				c.origin_x = pick_origin();
				c.origin_y = pick_origin();
				c.lighten_enable = 1'($urandom_range(0, 1));
			end
			cfg_write(REG_ANGLE, c.angle_deg);
			cfg_write(REG_SLICE_W, {7'd0, c.slice_width});
			cfg_write(REG_SLICE_H, {7'd0, c.slice_height});
			cfg_write(REG_SCALE_X, c.scale_x_q8);
			cfg_write(REG_SCALE_Y, c.scale_y_q8);
			cfg_write(REG_ORIGIN_X, c.origin_x);
			cfg_write(REG_ORIGIN_Y, c.origin_y);
			cfg_write(REG_LIGHTEN, {15'd0, c.lighten_enable});
			settings_used++;

			// no idling in the last phases; otherwise a random mix, sometimes none
			if (p >= NUM_PHASES - CALM_PHASES) begin
				tx_gap_pct = 0;
				rx_stall_pct = 0;
			end else begin
				case ($urandom_range(0, 3))
					0: tx_gap_pct = 0;
					1: tx_gap_pct = 10;
					2: tx_gap_pct = 25;
					default: tx_gap_pct = 50;
				endcase
				case ($urandom_range(0, 3))
					0: rx_stall_pct = 0;
					1: rx_stall_pct = 10;
					2: rx_stall_pct = 25;
					default: rx_stall_pct = 50;
				endcase
			end

			count = 0;
			while (count < ITEMS_PER_PHASE) begin
				pix = pick_pixel(shadow_cfg);
				send_pixel(pix, 0, '0);
				count++;
				// hold the sender once until the pipe has emptied
				if (p == HOLD_PHASE && count == ITEMS_PER_PHASE / 2 && !held) begin
					held = 1;
					wait_drained();
				end
			end
		end

		// Let everything drain, then report
		rx_stall_pct = 0;
		wait_drained();
		if (pending_rects.size() != 0) begin
			$display("%0d expected rectangles never arrived", pending_rects.size());
			mismatches++;
		end
		$display("Sent %0d pixels (%0d transparent) over %0d random register settings.",
			pixels_sent, transparent_sent, settings_used);
		$display("Checked %0d rectangles, %0d mismatches.", rects_checked, mismatches);
		if (mismatches == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

/* files.f */
sv/tspr_pkg.sv
sv/tspr_cfg_regs.sv
sv/tspr_front.sv
sv/tspr_shear.sv
sv/tspr_place.sv
sv/three_shear_pixel_rotator.sv
bench/three_shear_pixel_rotator_tb.sv
